// ===== src/complex_float_axpy_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the complex float axpy core
// Shared property forms, sampled on clk and masked while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef COMPLEX_FLOAT_AXPY_CORE_MACROS_SVH
`define COMPLEX_FLOAT_AXPY_CORE_MACROS_SVH

// Two signals that must agree on every edge
`define CFA_ASSERT_SAME(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ((lhs) == (rhs))) \
    else $error("signals disagree");

// A cause that must be followed by its effect a fixed number of cycles later
`define CFA_ASSERT_DELAY(label, cause, n, effect) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> ##n (effect)) \
    else $error("expected effect missing");

`endif

// ===== src/cfa_pkg.sv =====
// ---------------------------------------------------------------------------
// cfa_pkg
// Item types, binary32 constants and helpers for the complex float axpy core.
// ---------------------------------------------------------------------------
package cfa_pkg;

  // binary32 codes
  localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
  localparam logic [30:0] INF_MAG = 31'h7F80_0000;
  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

  // Register indexes of the write port
  localparam logic CFG_ALPHA_RE = 1'b0;
  localparam logic CFG_ALPHA_IM = 1'b1;

  // Pipeline depth of one fused multiply-add unit
  localparam int unsigned FMA_DEPTH = 7;

  typedef struct packed {
    logic [31:0] x_real;
    logic [31:0] x_imag;
    logic [31:0] y_real;
    logic [31:0] y_imag;
    logic        last_in;
  } in_t;

  typedef struct packed {
    logic [31:0] sum_real;
    logic [31:0] sum_imag;
    logic        last_out;
  } out_t;

  // Position of the highest set bit of a 64-bit word (0 when empty)
  function automatic logic [5:0] top_bit64(input logic [63:0] v);
    logic [5:0] k;
    k = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) k = 6'(i);
    end
    return k;
  endfunction

endpackage

// ===== src/cfa_fma.sv =====
// ---------------------------------------------------------------------------
// cfa_fma
// Seven-stage binary32 fused multiply-add a*b + c, round to nearest even.
// ---------------------------------------------------------------------------
module cfa_fma (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  output logic        out_valid,
  output logic [31:0] r
);

  localparam int unsigned DEPTH = cfa_pkg::FMA_DEPTH;

  // valid and special-result delay line
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] spec_r;
  logic [31:0]      specv_r [DEPTH];

  // stage 1: unpack, classify, multiply
  logic        nan_c, ia, ib, ic, za, zb, zc, ps, sc, spec_nxt;
  logic [31:0] specv_nxt;
  logic [23:0] ma, mb, mc;
  logic signed [11:0] ea, eb, ec;

  always_comb begin
    za  = (a[30:0] == 31'd0);
    zb  = (b[30:0] == 31'd0);
    zc  = (c[30:0] == 31'd0);
    ia  = (a[30:0] == cfa_pkg::INF_MAG);
    ib  = (b[30:0] == cfa_pkg::INF_MAG);
    ic  = (c[30:0] == cfa_pkg::INF_MAG);
    ps  = a[31] ^ b[31];
    sc  = c[31];
    nan_c = (a[30:0] > cfa_pkg::INF_MAG) || (b[30:0] > cfa_pkg::INF_MAG) ||
            (c[30:0] > cfa_pkg::INF_MAG);
    spec_nxt  = 1'b1;
    specv_nxt = c;
    if (nan_c) begin
      specv_nxt = cfa_pkg::QNAN32;
    end else if (ia || ib) begin
      if (za || zb || (ic && sc != ps)) specv_nxt = cfa_pkg::QNAN32;
      else specv_nxt = {ps, cfa_pkg::INF_MAG};
    end else if (ic) begin
      specv_nxt = c;
    end else if (za || zb) begin
      specv_nxt = zc ? {ps & sc, 31'd0} : c;
    end else begin
      spec_nxt = 1'b0;
    end
    if (a[30:23] == 8'd0) begin
      ma = {1'b0, a[22:0]};
      ea = -12'sd149;
    end else begin
      ma = {1'b1, a[22:0]};
      ea = $signed({4'd0, a[30:23]}) - 12'sd150;
    end
    if (b[30:23] == 8'd0) begin
      mb = {1'b0, b[22:0]};
      eb = -12'sd149;
    end else begin
      mb = {1'b1, b[22:0]};
      eb = $signed({4'd0, b[30:23]}) - 12'sd150;
    end
    if (c[30:23] == 8'd0) begin
      mc = {1'b0, c[22:0]};
      ec = -12'sd149;
    end else begin
      mc = {1'b1, c[22:0]};
      ec = $signed({4'd0, c[30:23]}) - 12'sd150;
    end
  end

  logic [47:0]        s1_prod_r;
  logic signed [11:0] s1_eab_r, s1_ec_r;
  logic [23:0]        s1_mc_r;
  logic               s1_ps_r, s1_sc_r, s1_zc_r;

  always_ff @(posedge clk) begin
    s1_prod_r <= ma * mb;
    s1_eab_r  <= ea + eb;
    s1_mc_r   <= mc;
    s1_ec_r   <= ec;
    s1_ps_r   <= ps;
    s1_sc_r   <= sc;
    s1_zc_r   <= zc;
  end

  // stage 2: normalise product and addend to bit 62
  logic [5:0] tb_p, tb_c;
  logic [6:0] sh_p, sh_c;

  always_comb begin
    tb_p = cfa_pkg::top_bit64({16'd0, s1_prod_r});
    tb_c = cfa_pkg::top_bit64({40'd0, s1_mc_r});
    sh_p = 7'd62 - {1'b0, tb_p};
    sh_c = 7'd62 - {1'b0, tb_c};
  end

  logic [63:0]        s2_big_r, s2_small_r;
  logic signed [11:0] s2_pe_r, s2_ec_r;
  logic               s2_ps_r, s2_sc_r, s2_zc_r;

  always_ff @(posedge clk) begin
    s2_big_r   <= {16'd0, s1_prod_r} << sh_p[5:0];
    s2_small_r <= {40'd0, s1_mc_r} << sh_c[5:0];
    s2_pe_r    <= s1_eab_r - $signed({5'd0, sh_p});
    s2_ec_r    <= s1_ec_r - $signed({5'd0, sh_c});
    s2_ps_r    <= s1_ps_r;
    s2_sc_r    <= s1_sc_r;
    s2_zc_r    <= s1_zc_r;
  end

  // stage 3: order by exponent and align the smaller term with sticky
  logic [63:0]        big3, small3, pre3, mask3;
  logic signed [11:0] be3, d3;
  logic               bs3, ss3, swap3;

  always_comb begin
    swap3 = !s2_zc_r && (s2_ec_r > s2_pe_r);
    if (swap3) begin
      big3 = s2_small_r;
      pre3 = s2_big_r;
      bs3  = s2_sc_r;
      ss3  = s2_ps_r;
      be3  = s2_ec_r;
      d3   = s2_ec_r - s2_pe_r;
    end else begin
      big3 = s2_big_r;
      pre3 = s2_small_r;
      bs3  = s2_ps_r;
      ss3  = s2_sc_r;
      be3  = s2_pe_r;
      d3   = s2_pe_r - s2_ec_r;
    end
    mask3 = ~({64{1'b1}} << d3[5:0]);
    if (s2_zc_r) begin
      small3 = 64'd0;
      ss3    = bs3;
    end else if (d3 >= 12'sd63) begin
      small3 = 64'd1;
    end else if (d3 > 12'sd0) begin
      small3 = (pre3 >> d3[5:0]) | {63'd0, |(pre3 & mask3)};
    end else begin
      small3 = pre3;
    end
  end

  logic [63:0]        s3_big_r, s3_small_r;
  logic signed [11:0] s3_be_r;
  logic               s3_bs_r, s3_ss_r;

  always_ff @(posedge clk) begin
    s3_big_r   <= big3;
    s3_small_r <= small3;
    s3_be_r    <= be3;
    s3_bs_r    <= bs3;
    s3_ss_r    <= ss3;
  end

  // stage 4: add or subtract magnitudes
  logic [63:0] sum4;
  logic        sg4;

  always_comb begin
    if (s3_bs_r == s3_ss_r) begin
      sum4 = s3_big_r + s3_small_r;
      sg4  = s3_bs_r;
    end else if (s3_big_r >= s3_small_r) begin
      sum4 = s3_big_r - s3_small_r;
      sg4  = s3_bs_r;
    end else begin
      sum4 = s3_small_r - s3_big_r;
      sg4  = s3_ss_r;
    end
  end

  logic [63:0]        s4_sum_r;
  logic signed [11:0] s4_be_r;
  logic               s4_sg_r;

  always_ff @(posedge clk) begin
    s4_sum_r <= sum4;
    s4_be_r  <= s3_be_r;
    s4_sg_r  <= sg4;
  end

  // stage 5: find the rounding position, clamped at the subnormal floor
  logic signed [11:0] q5, lo5;

  always_comb begin
    q5  = $signed({6'd0, cfa_pkg::top_bit64(s4_sum_r)}) - 12'sd23;
    lo5 = -12'sd149 - s4_be_r;
    if (q5 < lo5) q5 = lo5;
  end

  logic [63:0]        s5_sum_r;
  logic signed [11:0] s5_q_r, s5_be_r;
  logic               s5_sg_r, s5_zero_r;

  always_ff @(posedge clk) begin
    s5_sum_r  <= s4_sum_r;
    s5_q_r    <= q5;
    s5_be_r   <= s4_be_r;
    s5_sg_r   <= s4_sg_r;
    s5_zero_r <= (s4_sum_r == 64'd0);
  end

  // stage 6: shift the significand into place, extract guard and sticky
  logic [127:0]       t6;
  logic [63:0]        l6;
  logic signed [11:0] nq6;
  logic [23:0]        m6;
  logic               g6, st6;

  always_comb begin
    nq6 = -s5_q_r;
    t6  = {s5_sum_r, 64'd0} >> s5_q_r[6:0];
    l6  = s5_sum_r << nq6[4:0];
    if (s5_q_r <= 12'sd0) begin
      m6  = l6[23:0];
      g6  = 1'b0;
      st6 = 1'b0;
    end else if (s5_q_r >= 12'sd65) begin
      m6  = 24'd0;
      g6  = 1'b0;
      st6 = 1'b0;
    end else begin
      m6  = t6[87:64];
      g6  = t6[63];
      st6 = |t6[62:0];
    end
  end

  logic [23:0]        s6_m_r;
  logic signed [11:0] s6_bias_r;
  logic               s6_g_r, s6_st_r, s6_sg_r, s6_zero_r;

  always_ff @(posedge clk) begin
    s6_m_r    <= m6;
    s6_g_r    <= g6;
    s6_st_r   <= st6;
    s6_bias_r <= s5_q_r + s5_be_r + 12'sd149;
    s6_sg_r   <= s5_sg_r;
    s6_zero_r <= s5_zero_r;
  end

  // stage 7: round to nearest even, pack, pick special results
  logic [24:0]        m7;
  logic [23:0]        mf7;
  logic signed [11:0] bf7;
  logic [30:0]        mag7;
  logic [31:0]        r_nxt;

  always_comb begin
    m7 = {1'b0, s6_m_r} + {24'd0, s6_g_r && (s6_st_r || s6_m_r[0])};
    if (m7[24]) begin
      mf7 = m7[24:1];
      bf7 = s6_bias_r + 12'sd1;
    end else begin
      mf7 = m7[23:0];
      bf7 = s6_bias_r;
    end
    mag7 = {bf7[7:0], 23'd0} + {7'd0, mf7};
    if (bf7 + $signed({11'd0, mf7[23]}) >= 12'sd255) mag7 = cfa_pkg::INF_MAG;
    r_nxt = {s6_sg_r, mag7};
    if (spec_r[DEPTH-2]) r_nxt = specv_r[DEPTH-2];
    else if (s6_zero_r) r_nxt = 32'd0;
  end

  always_ff @(posedge clk) begin
    r <= r_nxt;
  end

  // advance valid and special flags alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    spec_r     <= {spec_r[DEPTH-2:0], spec_nxt};
    specv_r[0] <= specv_nxt;
    for (int i = 1; i < DEPTH; i++) begin
      specv_r[i] <= specv_r[i-1];
    end
  end

  assign out_valid = vld_r[DEPTH-1];

endmodule

// ===== src/complex_float_axpy_core.sv =====
// ---------------------------------------------------------------------------
// complex_float_axpy_core
// Streaming complex binary32 y := alpha*x + y with fused multiply-adds.
// ---------------------------------------------------------------------------
// Usage:
//   Load alpha through the write port (cfg_we, cfg_index 0 = real part,
//   1 = imaginary part) while no item is in flight.
//   Present an item on in_data with start high; busy is never raised, so
//   an item is taken on every cycle that start is high.
//   Each result appears on out_data for one cycle with out_valid high,
//   after passing through two chained seven-stage fused multiply-add
//   units. Throughput is one item per cycle.
//   When both alpha parts are zero the y parts come back unchanged.
//   The receiver cannot stall; results are simply presented in order.
//   Reset clears alpha and empties the pipeline; outside reset no item is
//   lost or repeated, and items in flight at reset are dropped.
// ---------------------------------------------------------------------------
`include "complex_float_axpy_core_macros.svh"

module complex_float_axpy_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  cfa_pkg::in_t   in_data,
  output logic           out_valid,
  output cfa_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [31:0]    cfg_wdata
);

  localparam int unsigned D1 = cfa_pkg::FMA_DEPTH;
  localparam int unsigned D2 = 2 * cfa_pkg::FMA_DEPTH;

  logic [31:0]  alpha_re_r, alpha_im_r;
  cfa_pkg::in_t item_r [D2];
  logic         acc;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  // hold the scale factor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_re_r <= '0;
      alpha_im_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cfa_pkg::CFG_ALPHA_RE: alpha_re_r <= cfg_wdata;
        cfa_pkg::CFG_ALPHA_IM: alpha_im_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // carry each item beside the arithmetic
  always_ff @(posedge clk) begin
    item_r[0] <= in_data;
    for (int i = 1; i < D2; i++) begin
      item_r[i] <= item_r[i-1];
    end
  end

  // first multiply-add of each lane
  logic        re1_v, im1_v, re2_v, im2_v;
  logic [31:0] re1, im1, re2, im2;

  cfa_fma u_re1 (
    .clk(clk), .rst_n(rst_n), .in_valid(acc),
    .a(alpha_re_r), .b(in_data.x_real), .c(in_data.y_real),
    .out_valid(re1_v), .r(re1)
  );

  cfa_fma u_im1 (
    .clk(clk), .rst_n(rst_n), .in_valid(acc),
    .a(alpha_re_r), .b(in_data.x_imag), .c(in_data.y_imag),
    .out_valid(im1_v), .r(im1)
  );

  // second multiply-add, operands from the delayed item
  cfa_fma u_re2 (
    .clk(clk), .rst_n(rst_n), .in_valid(re1_v),
    .a(alpha_im_r ^ cfa_pkg::SIGN_BIT), .b(item_r[D1-1].x_imag), .c(re1),
    .out_valid(re2_v), .r(re2)
  );

  cfa_fma u_im2 (
    .clk(clk), .rst_n(rst_n), .in_valid(im1_v),
    .a(alpha_im_r), .b(item_r[D1-1].x_real), .c(im1),
    .out_valid(im2_v), .r(im2)
  );

  // pass y through when alpha is zero
  logic zero_alpha;

  always_comb begin
    zero_alpha = (alpha_re_r[30:0] == 31'd0) && (alpha_im_r[30:0] == 31'd0);
    out_valid  = re2_v;
    out_data.last_out = item_r[D2-1].last_in;
    if (zero_alpha) begin
      out_data.sum_real = item_r[D2-1].y_real;
      out_data.sum_imag = item_r[D2-1].y_imag;
    end else begin
      out_data.sum_real = re2;
      out_data.sum_imag = im2;
    end
  end

  `CFA_ASSERT_SAME(a_lanes_first, re1_v, im1_v)
  `CFA_ASSERT_SAME(a_lanes_second, re2_v, im2_v)
  `CFA_ASSERT_DELAY(a_chain, re1_v, 7, out_valid)

endmodule

// ===== sim/complex_float_axpy_core_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// complex_float_axpy_core_tb
// Drives complex binary32 items through the axpy core under several alpha
// settings and sender gap rates, predicts results with a bit-exact fused
// multiply-add model or directed rows, checks each strobed result in order.
// ---------------------------------------------------------------------------
module complex_float_axpy_core_tb;

  localparam int PIPE_LAT = 14;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [31:0] F_ONE = 32'h3F80_0000;
  localparam logic [31:0] F_MAXN = 32'h7F7F_FFFF;
  localparam logic [31:0] F_MINSUB = 32'h0000_0001;
  localparam logic [31:0] F_MAXSUB = 32'h007F_FFFF;
  localparam logic [31:0] F_INF = 32'h7F80_0000;
  localparam logic [31:0] F_SNAN = 32'h7F80_0001;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  cfa_pkg::in_t in_data = '0;
  logic out_valid;
  cfa_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;

  complex_float_axpy_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Scale factor as the block should hold it
  logic [31:0] alpha_re = '0;
  logic [31:0] alpha_im = '0;
  cfa_pkg::out_t pending_sums[$];
  int mismatches = 0;
  int results_seen = 0;
  int cycles = 0;

  // ---- binary32 arithmetic -------------------------------------------------
  function automatic int msb_pos(input logic [63:0] v);
    int k;
    k = 0;
    for (int i = 0; i < 64; i++) if (v[i]) k = i;
    return k;
  endfunction

  // Round sig * 2^ex once to binary32 (sig nonzero)
  function automatic logic [31:0] round_f32(input logic sgn, input logic [63:0] sig,
                                            input int ex);
    int q, lo, biased;
    logic [63:0] m, rem, half;
    q = msb_pos(sig) - 23;
    lo = -149 - ex;
    if (q < lo) q = lo;
    if (q <= 0) begin
      m = sig << (-q);
    end else if (q >= 64) begin
      m = (q == 64 && sig > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
    end else begin
      rem = sig & ((64'd1 << q) - 64'd1);
      half = 64'd1 << (q - 1);
      m = sig >> q;
      if (rem > half || (rem == half && m[0])) m = m + 64'd1;
    end
    biased = q + ex + 149;
    if (m == (64'd1 << 24)) begin
      m = m >> 1;
      biased++;
    end
    if (biased + int'(m >> 23) >= 255) return {sgn, 31'h7F80_0000};
    return {sgn, 31'd0} | ((32'(biased) << 23) + m[31:0]);
  endfunction

  function automatic void split_f32(input logic [31:0] f, output logic [63:0] m,
                                    output int ex);
    if (f[30:23] == 8'd0) begin
      m = {41'd0, f[22:0]};
      ex = -149;
    end else begin
      m = {40'd0, 1'b1, f[22:0]};
      ex = int'(f[30:23]) - 150;
    end
  endfunction

  // a*b + c with a single rounding
  function automatic logic [31:0] fma_f32(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
    logic ps, sc, za, zb, zc, ia, ib, ic, bs, ss;
    logic [63:0] ma, mb, mc, big, sml, lost, t;
    int ea, eb, ec, pe, sh, be, d;
    ps = a[31] ^ b[31];
    sc = c[31];
    za = a[30:0] == 0; zb = b[30:0] == 0; zc = c[30:0] == 0;
    ia = a[30:0] == cfa_pkg::INF_MAG;
    ib = b[30:0] == cfa_pkg::INF_MAG;
    ic = c[30:0] == cfa_pkg::INF_MAG;
    if (a[30:0] > cfa_pkg::INF_MAG || b[30:0] > cfa_pkg::INF_MAG ||
        c[30:0] > cfa_pkg::INF_MAG) return cfa_pkg::QNAN32;
    if (ia || ib) begin
      if (za || zb) return cfa_pkg::QNAN32;
      if (ic && sc != ps) return cfa_pkg::QNAN32;
      return {ps, cfa_pkg::INF_MAG};
    end
    if (ic) return c;
    if (za || zb) begin
      if (zc) return {ps & sc, 31'd0};
      return c;
    end
    split_f32(a, ma, ea);
    split_f32(b, mb, eb);
    big = ma * mb;
    sh = 62 - msb_pos(big);
    big = big << sh;
    pe = ea + eb - sh;
    if (zc) return round_f32(ps, big, pe);
    split_f32(c, mc, ec);
    sh = 62 - msb_pos(mc);
    sml = mc << sh;
    ec = ec - sh;
    bs = ps; ss = sc; be = pe;
    if (ec > pe) begin
      t = big; big = sml; sml = t;
      bs = sc; ss = ps; be = ec;
      d = ec - pe;
    end else begin
      d = pe - ec;
    end
    if (d >= 63) begin
      sml = 64'd1;
    end else if (d > 0) begin
      lost = sml & ((64'd1 << d) - 64'd1);
      sml = (sml >> d) | (lost != 0 ? 64'd1 : 64'd0);
    end
    if (bs == ss) return round_f32(bs, big + sml, be);
    if (big == sml) return 32'd0;
    if (big > sml) return round_f32(bs, big - sml, be);
    return round_f32(ss, sml - big, be);
  endfunction

  function automatic cfa_pkg::out_t axpy_result(input cfa_pkg::in_t it);
    cfa_pkg::out_t r;
    r.sum_real = it.y_real;
    r.sum_imag = it.y_imag;
    if (alpha_re[30:0] != 0 || alpha_im[30:0] != 0) begin
      r.sum_real = fma_f32(alpha_im ^ cfa_pkg::SIGN_BIT, it.x_imag,
                           fma_f32(alpha_re, it.x_real, it.y_real));
      r.sum_imag = fma_f32(alpha_im, it.x_real, fma_f32(alpha_re, it.x_imag, it.y_imag));
    end
    r.last_out = it.last_in;
    return r;
  endfunction

  // ---- result checking -----------------------------------------------------
  task automatic report_bad(input cfa_pkg::out_t want, input cfa_pkg::out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at cycle %0d: expected %h %h %b, got %h %h %b", cycles,
               want.sum_real, want.sum_imag, want.last_out,
               got.sum_real, got.sum_imag, got.last_out);
  endtask

  // Sample mid-cycle so the strobe is stable
  always @(negedge clk) begin
    cfa_pkg::out_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d: %h", cycles, out_data);
      end else begin
        want = pending_sums.pop_front();
        if (want.sum_real !== out_data.sum_real || want.sum_imag !== out_data.sum_imag ||
            want.last_out !== out_data.last_out)
          report_bad(want, out_data);
      end
    end
  end

  // Hard stop on a hang
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---- stimulus helpers ----------------------------------------------------
  // Present one item, hold until taken, record its expected result
  task automatic push_item(input cfa_pkg::in_t it, input logic typed,
                           input cfa_pkg::out_t want);
    start <= 1'b1;
    in_data <= it;
    do @(negedge clk); while (busy);
    @(posedge clk);
    pending_sums.push_back(typed ? want : axpy_result(it));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_alpha(input logic [31:0] re, input logic [31:0] im);
    cfg_we <= 1'b1; cfg_index <= cfa_pkg::CFG_ALPHA_RE; cfg_wdata <= re;
    @(posedge clk);
    cfg_index <= cfa_pkg::CFG_ALPHA_IM; cfg_wdata <= im;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    alpha_re = re;
    alpha_im = im;
  endtask

  // Mix of special classes and values in a band where terms interact
  function automatic logic [31:0] pick_f32();
    logic [31:0] f;
    f = $urandom;
    case ($urandom_range(0, 15))
      0: f = {f[31], 31'd0};
      1: f = {f[31], 8'd0, f[22:0]};
      2: f = {f[31], cfa_pkg::INF_MAG};
      3: f = {f[31], 8'hFF, f[22:0] | 23'd1};
      4: f = {f[31], 8'hFE, f[22:0]};
      5: f = {f[31], 8'(f[24:23] + 1), f[22:0]};
      6, 7, 8: f = {f[31], 8'($urandom_range(118, 136)), f[22:0]};
      9: f = {f[31], 8'($urandom_range(118, 136)), f[22:18], 18'd0};
      default: ;
    endcase
    return f;
  endfunction

  typedef struct {
    logic [31:0] a_re, a_im;
    cfa_pkg::in_t it;
    logic typed;
    cfa_pkg::out_t want;
  } stim_row_t;

  stim_row_t dir_rows[$];

  function automatic stim_row_t mk_row(input logic [31:0] are, input logic [31:0] aim,
                                       input logic [31:0] xr, input logic [31:0] xi,
                                       input logic [31:0] yr, input logic [31:0] yi,
                                       input logic lst, input logic typed,
                                       input logic [31:0] wr, input logic [31:0] wi);
    stim_row_t r;
    r.a_re = are; r.a_im = aim;
    r.it = '{x_real: xr, x_imag: xi, y_real: yr, y_imag: yi, last_in: lst};
    r.typed = typed;
    r.want = '{sum_real: wr, sum_imag: wi, last_out: lst};
    return r;
  endfunction

  initial begin
    int idle_pct[4] = '{0, 65, 0, 34};
    logic [31:0] phase_re[4] = '{F_ONE, F_MAXN, 32'h8000_0000, 32'hBFC0_0000};
    logic [31:0] phase_im[4] = '{32'h4000_0000, F_MINSUB, F_MAXSUB, 32'h3E80_0000};
    cfa_pkg::in_t it;
    cfa_pkg::out_t none;
    none = '0;

    // Zero alpha: y returned bit for bit, even with non-finite x
    dir_rows.push_back(mk_row(0, 0, F_INF, F_SNAN, 32'h1234_5678, 32'h8765_4321, 1'b1, 1'b1,
                              32'h1234_5678, 32'h8765_4321));
    dir_rows.push_back(mk_row(0, 0, '1, '1, '1, '1, 1'b0, 1'b1, '1, '1));
    dir_rows.push_back(mk_row(32'h8000_0000, 32'h8000_0000, F_MAXN, F_ONE, 0, 32'h8000_0000,
                              1'b1, 1'b1, 0, 32'h8000_0000));
    // NaN operand gives the canonical quiet NaN
    dir_rows.push_back(mk_row(F_ONE, 0, F_SNAN, F_ONE, F_ONE, F_ONE, 1'b0, 1'b1,
                              cfa_pkg::QNAN32, cfa_pkg::QNAN32));
    dir_rows.push_back(mk_row(F_ONE, 0, F_ONE, F_ONE, 32'hFFC0_0001, F_ONE, 1'b1, 1'b1,
                              cfa_pkg::QNAN32, 32'h4000_0000));
    // Infinity times zero, opposite infinities
    dir_rows.push_back(mk_row(F_ONE, 0, F_INF, 0, 0, 0, 1'b0, 1'b1, F_INF, cfa_pkg::QNAN32));
    dir_rows.push_back(mk_row(F_ONE, 0, F_INF, 0, 32'hFF80_0000, 0, 1'b0, 1'b1,
                              cfa_pkg::QNAN32, cfa_pkg::QNAN32));
    // Exact cancellation gives +0; signed zeros
    dir_rows.push_back(mk_row(F_ONE, 0, F_ONE, F_ONE, 32'hBF80_0000, 32'hBF80_0000, 1'b1, 1'b1,
                              0, 0));
    dir_rows.push_back(mk_row(F_ONE, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              0, 1'b0, 1'b1, 0, 0));
    // Overflow to infinity, subnormals, mixed alpha
    dir_rows.push_back(mk_row(F_MAXN, F_MAXN, F_MAXN, 32'hFF7F_FFFF, F_MAXN, 0, 1'b1, 1'b0,
                              0, 0));
    dir_rows.push_back(mk_row(F_MINSUB, F_MAXSUB, F_MINSUB, F_MAXSUB, F_MINSUB, 32'h8000_0001,
                              1'b0, 1'b0, 0, 0));
    dir_rows.push_back(mk_row(32'h3F00_0000, 32'hBF00_0000, 32'h3F80_0001, 32'h4B80_0001,
                              32'hB3FF_FFFF, 32'h0080_0000, 1'b1, 1'b0, 0, 0));
    dir_rows.push_back(mk_row(32'h3F00_0000, 32'hBF00_0000, '0, 32'h7F7F_FFFF, '1 >> 1,
                              32'hFF7F_FFFF, 1'b0, 1'b0, 0, 0));
    dir_rows.push_back(mk_row(F_INF, 0, F_ONE, F_ONE, F_ONE, F_ONE, 1'b1, 1'b0, 0, 0));

    // Hold reset, then release it
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].a_re !== alpha_re || dir_rows[i].a_im !== alpha_im) begin
        drain();
        write_alpha(dir_rows[i].a_re, dir_rows[i].a_im);
      end
      push_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases, each with its own alpha and a gap rate
    for (int p = 0; p < 4; p++) begin
      drain();
      write_alpha(phase_re[p], phase_im[p]);
      for (int n = 0; n < 410; n++) begin
        if (idle_pct[p] != 0) begin
          while ($urandom_range(1, 100) <= idle_pct[p]) begin
            start <= 1'b0;
            @(posedge clk);
          end
        end
        // Let the pipe run dry once mid-phase
        if (p == 1 && n == 200) begin
          start <= 1'b0;
          do @(posedge clk); while (pending_sums.size() != 0);
        end
        it.x_real = pick_f32();
        it.x_imag = pick_f32();
        it.y_real = pick_f32();
        it.y_imag = pick_f32();
        it.last_in = 1'($urandom);
        push_item(it, 1'b0, none);
      end
    end

    start <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 6) @(posedge clk);

    $display("covered zero alpha, NaN, infinity, cancellation, overflow and subnormal cases;");
    $display("%0d results checked over a range of alpha settings and three gap rates",
             results_seen);
    if (mismatches == 0 && pending_sums.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, pending_sums.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
